>>> hdl/tset_pkg.sv
// Shared constants, codes and types for the time-sorted event table.
`timescale 1ns / 1ps

package tset_pkg;

    // Table size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int CMD_W    = 2;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int TAG_W    = 16;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int KEY_W    = HOUR_W + MINUTE_W;

    // Width wide enough to compare a position against a count
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

    // One stored entry
    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [TAG_W-1:0]    tag;
    } t_entry;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the input beat
        logic exec;   // apply the command and register the result
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
    } t_dp_status;

endpackage

>>> hdl/time_sorted_event_table_core.sv
// Top level of the time-sorted event table: controller plus datapath.
// An accepted beat is held in the input registers; exec then loads the result register.
// The controller takes a beat and applies it when the output is free, then takes the next.
// A result may wait in the output register while the next input beat is taken.
// Reset (synchronous, active low) empties the table and drops any pending result.
// Entry cells are not cleared; entries past the count are never read.
`timescale 1ns / 1ps

module time_sorted_event_table_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [tset_pkg::CMD_W-1:0]          i_cmd,
    input  logic [tset_pkg::HOUR_W-1:0]         i_new_hour,
    input  logic [tset_pkg::MINUTE_W-1:0]       i_new_minute,
    input  logic [tset_pkg::TAG_W-1:0]          i_new_tag,
    input  logic [tset_pkg::POS_W-1:0]          i_position,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tset_pkg::STATUS_W-1:0]       o_status,
    output logic [tset_pkg::HOUR_W-1:0]         o_out_hour,
    output logic [tset_pkg::MINUTE_W-1:0]       o_out_minute,
    output logic [tset_pkg::TAG_W-1:0]          o_out_tag,
    output logic [tset_pkg::CNT_W-1:0]          o_entry_count
);

    tset_pkg::t_dp_cmd    dp_cmd;
    tset_pkg::t_dp_status dp_status;

    // Sequencing
    tset_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_dp_status (dp_status),
        .o_dp_cmd    (dp_cmd)
    );

    // Table, count and result register
    tset_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_cmd      (dp_cmd),
        .o_dp_status   (dp_status),
        .i_cmd         (i_cmd),
        .i_new_hour    (i_new_hour),
        .i_new_minute  (i_new_minute),
        .i_new_tag     (i_new_tag),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_out_hour    (o_out_hour),
        .o_out_minute  (o_out_minute),
        .o_out_tag     (o_out_tag),
        .o_entry_count (o_entry_count)
    );

endmodule

>>> hdl/tset_ctrl.sv
// Controller state machine of the time-sorted event table.
`timescale 1ns / 1ps

module tset_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tset_pkg::t_dp_status  i_dp_status,
    output tset_pkg::t_dp_cmd     o_dp_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_dp_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Handshake and datapath commands
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_dp_cmd.load = (r_state == S_IDLE) && i_in_valid;
    assign o_dp_cmd.exec = (r_state == S_EXEC) && i_dp_status.out_free;

endmodule

>>> hdl/tset_dpath.sv
// Datapath: entry cells with parallel compare and shift, count and result register.
`timescale 1ns / 1ps

module tset_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tset_pkg::t_dp_cmd                   i_dp_cmd,
    output tset_pkg::t_dp_status                o_dp_status,
    input  logic [tset_pkg::CMD_W-1:0]          i_cmd,
    input  logic [tset_pkg::HOUR_W-1:0]         i_new_hour,
    input  logic [tset_pkg::MINUTE_W-1:0]       i_new_minute,
    input  logic [tset_pkg::TAG_W-1:0]          i_new_tag,
    input  logic [tset_pkg::POS_W-1:0]          i_position,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tset_pkg::STATUS_W-1:0]       o_status,
    output logic [tset_pkg::HOUR_W-1:0]         o_out_hour,
    output logic [tset_pkg::MINUTE_W-1:0]       o_out_minute,
    output logic [tset_pkg::TAG_W-1:0]          o_out_tag,
    output logic [tset_pkg::CNT_W-1:0]          o_entry_count
);

    // Captured input beat
    logic [tset_pkg::CMD_W-1:0] r_cmd;
    logic [tset_pkg::POS_W-1:0] r_pos;
    tset_pkg::t_entry           r_new;

    // Table state
    tset_pkg::t_entry           r_cell [tset_pkg::CAPACITY];
    tset_pkg::t_entry           n_cell [tset_pkg::CAPACITY];
    logic [tset_pkg::CNT_W-1:0] r_count;
    logic [tset_pkg::CNT_W-1:0] n_count;

    // Result register
    logic                          r_out_valid;
    logic [tset_pkg::STATUS_W-1:0] r_status;
    logic [tset_pkg::STATUS_W-1:0] n_status;
    tset_pkg::t_entry              r_out;
    tset_pkg::t_entry              n_out;

    logic [tset_pkg::CAPACITY-1:0] le;
    logic [tset_pkg::KEY_W-1:0]    new_key;
    logic                          full;
    logic                          empty;
    logic                          bad_idx;
    logic [tset_pkg::IDX_W-1:0]    rd_idx;

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd        <= i_cmd;
            r_pos        <= i_position;
            r_new.hour   <= i_new_hour;
            r_new.minute <= i_new_minute;
            r_new.tag    <= i_new_tag;
        end
    end

    assign new_key = {r_new.hour, r_new.minute};
    assign full    = (r_count == tset_pkg::CNT_W'(tset_pkg::CAPACITY));
    assign empty   = (r_count == '0);
    assign bad_idx = (tset_pkg::CMP_W'(r_pos) >= tset_pkg::CMP_W'(r_count));
    assign rd_idx  = tset_pkg::IDX_W'(r_pos);

    // Per-cell compare: valid and time earlier or equal to the new entry
    always_comb begin
        for (int i = 0; i < tset_pkg::CAPACITY; i++) begin
            le[i] = (tset_pkg::CNT_W'(i) < r_count) &&
                    ({r_cell[i].hour, r_cell[i].minute} <= new_key);
        end
    end

    // Next cell contents: open a slot on insert, close the gap on delete
    always_comb begin
        for (int i = 0; i < tset_pkg::CAPACITY; i++) begin
            n_cell[i] = r_cell[i];
        end
        if (i_dp_cmd.exec && (r_cmd == tset_pkg::CMD_INSERT) && !full) begin
            if (!le[0]) begin
                n_cell[0] = r_new;
            end
            for (int i = 1; i < tset_pkg::CAPACITY; i++) begin
                if (!le[i]) begin
                    n_cell[i] = le[i-1] ? r_new : r_cell[i-1];
                end
            end
        end else if (i_dp_cmd.exec && (r_cmd == tset_pkg::CMD_DELETE) &&
                     !empty && !bad_idx) begin
            for (int i = 0; i < tset_pkg::CAPACITY - 1; i++) begin
                if (tset_pkg::CMP_W'(i) >= tset_pkg::CMP_W'(r_pos)) begin
                    n_cell[i] = r_cell[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < tset_pkg::CAPACITY; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

    // Status, read data and next count
    always_comb begin
        n_status = tset_pkg::ST_OK;
        n_out    = '0;
        n_count  = r_count;
        case (r_cmd)
            tset_pkg::CMD_INSERT: begin
                if (full) begin
                    n_status = tset_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            tset_pkg::CMD_DELETE: begin
                if (empty) begin
                    n_status = tset_pkg::ST_EMPTY;
                end else if (bad_idx) begin
                    n_status = tset_pkg::ST_BADIDX;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            tset_pkg::CMD_READ: begin
                if (empty) begin
                    n_status = tset_pkg::ST_EMPTY;
                end else if (bad_idx) begin
                    n_status = tset_pkg::ST_BADIDX;
                end else begin
                    n_out = r_cell[rd_idx];
                end
            end
            default: n_status = tset_pkg::ST_OK;
        endcase
    end

    // Count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_dp_cmd.exec) begin
            r_count <= n_count;
        end
    end

    // Result register: loaded on exec, held until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.exec) begin
            r_status <= n_status;
            r_out    <= n_out;
        end
    end

    assign o_dp_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_out_hour    = r_out.hour;
    assign o_out_minute  = r_out.minute;
    assign o_out_tag     = r_out.tag;
    assign o_entry_count = r_count;

    // Count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tset_pkg::CNT_W'(tset_pkg::CAPACITY))
        else $error("entry count above capacity");

    // Count moves only on exec, and by one at most
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_dp_cmd.exec |=> $stable(r_count))
        else $error("entry count changed without a command");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.exec |=> (r_count == $past(r_count)) ||
                          (r_count == $past(r_count) + 1'b1) ||
                          (r_count == $past(r_count) - 1'b1))
        else $error("entry count moved by more than one");

    // Exec never overwrites a result that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.exec |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // A full table reports full on insert
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dp_cmd.exec && (r_cmd == tset_pkg::CMD_INSERT) && full) |=>
            (r_status == tset_pkg::ST_FULL) && r_out_valid)
        else $error("insert on full table not reported");

endmodule

>>> test/time_sorted_event_table_core_tb.sv
// Self-checking testbench for the time-sorted event table core.
`timescale 1ns / 1ps

module time_sorted_event_table_core_tb;

    // cmd code 3 has no operation behind it
    localparam logic [tset_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_BEATS = 950;
    localparam int SEGMENT_LEN  = 30;

    typedef enum int { MODE_FILL, MODE_DRAIN, MODE_MIX } t_traffic_mode;

    // One result beat as seen on the output port
    typedef struct packed {
        logic [tset_pkg::STATUS_W-1:0] status;
        logic [tset_pkg::HOUR_W-1:0]   hour;
        logic [tset_pkg::MINUTE_W-1:0] minute;
        logic [tset_pkg::TAG_W-1:0]    tag;
        logic [tset_pkg::CNT_W-1:0]    count;
    } t_table_result;

    // Shadow table plus the queue of results still owed by the block
    class event_table_scoreboard;
        tset_pkg::t_entry slots [tset_pkg::CAPACITY];
        int               count;
        int               errors;
        t_table_result    expected_results [$];

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        // Apply one accepted command beat and queue the result it must produce
        function void note_command(input logic [tset_pkg::CMD_W-1:0] cmd,
                                   input logic [tset_pkg::HOUR_W-1:0] hour,
                                   input logic [tset_pkg::MINUTE_W-1:0] minute,
                                   input logic [tset_pkg::TAG_W-1:0] tag,
                                   input logic [tset_pkg::POS_W-1:0] pos);
            t_table_result res;
            int            at;
            res        = '0;
            res.status = tset_pkg::ST_OK;
            case (cmd)
                tset_pkg::CMD_INSERT: begin
                    if (count >= tset_pkg::CAPACITY) begin
                        res.status = tset_pkg::ST_FULL;
                    end else begin
                        // land after every entry with an earlier or equal time
                        at = count;
                        while (at > 0 &&
                               {slots[at-1].hour, slots[at-1].minute} > {hour, minute})
                            at--;
                        for (int k = count; k > at; k--)
                            slots[k] = slots[k-1];
                        slots[at].hour   = hour;
                        slots[at].minute = minute;
                        slots[at].tag    = tag;
                        count++;
                    end
                end
                tset_pkg::CMD_DELETE: begin
                    if (count == 0) begin
                        res.status = tset_pkg::ST_EMPTY;
                    end else if (int'(pos) >= count) begin
                        res.status = tset_pkg::ST_BADIDX;
                    end else begin
                        for (int k = int'(pos); k + 1 < count; k++)
                            slots[k] = slots[k+1];
                        count--;
                    end
                end
                tset_pkg::CMD_READ: begin
                    if (count == 0) begin
                        res.status = tset_pkg::ST_EMPTY;
                    end else if (int'(pos) >= count) begin
                        res.status = tset_pkg::ST_BADIDX;
                    end else begin
                        res.hour   = slots[pos].hour;
                        res.minute = slots[pos].minute;
                        res.tag    = slots[pos].tag;
                    end
                end
                default: ;
            endcase
            res.count = tset_pkg::CNT_W'(count);
            expected_results.push_back(res);
        endfunction

        function void compare_field(input string name,
                                    input logic [tset_pkg::TAG_W-1:0] exp_val,
                                    input logic [tset_pkg::TAG_W-1:0] act_val);
            if (act_val !== exp_val) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
                errors++;
            end
        endfunction

        // Match one output beat against the oldest pending result
        function void check_result(input t_table_result act);
            t_table_result exp;
            if (expected_results.size() == 0) begin
                $display("%0t: result beat with none expected, status %0d count %0d",
                         $time, act.status, act.count);
                errors++;
                return;
            end
            exp = expected_results.pop_front();
            compare_field("status", tset_pkg::TAG_W'(exp.status),
                          tset_pkg::TAG_W'(act.status));
            compare_field("out_hour", tset_pkg::TAG_W'(exp.hour),
                          tset_pkg::TAG_W'(act.hour));
            compare_field("out_minute", tset_pkg::TAG_W'(exp.minute),
                          tset_pkg::TAG_W'(act.minute));
            compare_field("out_tag", exp.tag, act.tag);
            compare_field("entry_count", tset_pkg::TAG_W'(exp.count),
                          tset_pkg::TAG_W'(act.count));
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [tset_pkg::CMD_W-1:0]    i_cmd;
    logic [tset_pkg::HOUR_W-1:0]   i_new_hour;
    logic [tset_pkg::MINUTE_W-1:0] i_new_minute;
    logic [tset_pkg::TAG_W-1:0]    i_new_tag;
    logic [tset_pkg::POS_W-1:0]    i_position;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic [tset_pkg::STATUS_W-1:0] o_status;
    logic [tset_pkg::HOUR_W-1:0]   o_out_hour;
    logic [tset_pkg::MINUTE_W-1:0] o_out_minute;
    logic [tset_pkg::TAG_W-1:0]    o_out_tag;
    logic [tset_pkg::CNT_W-1:0]    o_entry_count;

    event_table_scoreboard sb;
    int in_idle_pct;
    int out_stall_pct;
    int hold_cycles;

    time_sorted_event_table_core i_dut (.*);

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("time_sorted_event_table_core: mismatch");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= out_stall_pct);
            end
        end
    end

    // Output monitor: values sampled here are the ones present before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result('{o_status, o_out_hour, o_out_minute, o_out_tag, o_entry_count});
    end

    // Offer one command beat after a random gap and hold it until accepted
    task automatic send_command(input logic [tset_pkg::CMD_W-1:0] cmd,
                                input logic [tset_pkg::HOUR_W-1:0] hour,
                                input logic [tset_pkg::MINUTE_W-1:0] minute,
                                input logic [tset_pkg::TAG_W-1:0] tag,
                                input logic [tset_pkg::POS_W-1:0] pos);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < in_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_new_hour   <= hour;
        i_new_minute <= minute;
        i_new_tag    <= tag;
        i_position   <= pos;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_command(cmd, hour, minute, tag, pos);
    endtask

    // Sender pause until every queued result has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    // Random command beat, weighted by the current traffic mode
    task automatic send_random(input t_traffic_mode mode);
        logic [tset_pkg::CMD_W-1:0]    cmd;
        logic [tset_pkg::HOUR_W-1:0]   hour;
        logic [tset_pkg::MINUTE_W-1:0] minute;
        logic [tset_pkg::POS_W-1:0]    pos;
        int                            pick;
        pick = $urandom_range(99);
        case (mode)
            MODE_FILL:  cmd = (pick < 70) ? tset_pkg::CMD_INSERT :
                              (pick < 85) ? tset_pkg::CMD_DELETE :
                              (pick < 96) ? tset_pkg::CMD_READ : CMD_UNUSED;
            MODE_DRAIN: cmd = (pick < 15) ? tset_pkg::CMD_INSERT :
                              (pick < 75) ? tset_pkg::CMD_DELETE :
                              (pick < 96) ? tset_pkg::CMD_READ : CMD_UNUSED;
            default:    cmd = (pick < 35) ? tset_pkg::CMD_INSERT :
                              (pick < 65) ? tset_pkg::CMD_DELETE :
                              (pick < 95) ? tset_pkg::CMD_READ : CMD_UNUSED;
        endcase
        // mostly legal times, a band of colliding times, and some out of range
        pick = $urandom_range(99);
        if (pick < 20) begin
            hour   = tset_pkg::HOUR_W'($urandom_range(9, 8));
            minute = ($urandom_range(1) != 0) ? 6'd30 : 6'd0;
        end else if (pick < 88) begin
            hour   = tset_pkg::HOUR_W'($urandom_range(23));
            minute = tset_pkg::MINUTE_W'($urandom_range(59));
        end else begin
            hour   = tset_pkg::HOUR_W'($urandom_range(31));
            minute = tset_pkg::MINUTE_W'($urandom_range(63));
        end
        // positions mostly inside the table
        if (sb.count > 0 && $urandom_range(99) < 80)
            pos = tset_pkg::POS_W'($urandom_range(sb.count - 1));
        else
            pos = tset_pkg::POS_W'($urandom_range(15));
        send_command(cmd, hour, minute, tset_pkg::TAG_W'($urandom_range(16'hFFFF)), pos);
    endtask

    initial begin
        t_traffic_mode mode;
        sb            = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cmd         = tset_pkg::CMD_INSERT;
        i_new_hour    = '0;
        i_new_minute  = '0;
        i_new_tag     = '0;
        i_position    = '0;
        hold_cycles   = 0;
        in_idle_pct   = 6;
        out_stall_pct = 52;
        mode          = MODE_MIX;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: read, delete and the unused code with all-ones payload
        send_command(tset_pkg::CMD_READ, 5'd0, 6'd0, 16'h0000, 4'd0);
        send_command(tset_pkg::CMD_DELETE, 5'd0, 6'd0, 16'h0000, 4'd15);
        send_command(CMD_UNUSED, 5'h1F, 6'h3F, 16'hFFFF, 4'hF);

        // Extremes, a tie and an out-of-range time
        send_command(tset_pkg::CMD_INSERT, 5'd23, 6'd59, 16'hFFFF, 4'd0);
        send_command(tset_pkg::CMD_INSERT, 5'd0, 6'd0, 16'h0000, 4'd0);
        send_command(tset_pkg::CMD_INSERT, 5'd12, 6'd30, 16'h1234, 4'd0);
        send_command(tset_pkg::CMD_INSERT, 5'd12, 6'd30, 16'h5678, 4'd0);
        send_command(tset_pkg::CMD_INSERT, 5'h1F, 6'h3F, 16'hAAAA, 4'd0);

        // Tie order, then index past the count
        send_command(tset_pkg::CMD_READ, 5'd0, 6'd0, 16'h0000, 4'd1);
        send_command(tset_pkg::CMD_READ, 5'd0, 6'd0, 16'h0000, 4'd2);
        send_command(tset_pkg::CMD_READ, 5'd0, 6'd0, 16'h0000, 4'd15);
        send_command(tset_pkg::CMD_DELETE, 5'd0, 6'd0, 16'h0000, 4'd15);

        // Fill up, overflow, then remove the last entry
        for (int n = 0; n < 11; n++)
            send_command(tset_pkg::CMD_INSERT,
                         tset_pkg::HOUR_W'($urandom_range(23)),
                         tset_pkg::MINUTE_W'($urandom_range(59)),
                         tset_pkg::TAG_W'($urandom_range(16'hFFFF)),
                         tset_pkg::POS_W'($urandom_range(15)));
        send_command(tset_pkg::CMD_INSERT, 5'd6, 6'd6, 16'h0BAD, 4'd0);
        send_command(tset_pkg::CMD_DELETE, 5'd0, 6'd0, 16'h0000, 4'd15);
        send_command(tset_pkg::CMD_READ, 5'd0, 6'd0, 16'h0000, 4'd0);
        wait_for_results();

        // Random traffic in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin in_idle_pct = 6;  out_stall_pct = 52; end
                1: begin in_idle_pct = 52; out_stall_pct = 6;  end
                default: begin in_idle_pct = 0; out_stall_pct = 0; end
            endcase
            for (int n = 0; n < RANDOM_BEATS / 3; n++) begin
                if (n % SEGMENT_LEN == 0)
                    mode = t_traffic_mode'($urandom_range(2));
                // long receiver hold-off while beats keep coming
                if (n == 100)
                    hold_cycles = 80;
                send_random(mode);
            end
            wait_for_results();
        end

        // Let any stray beat show up before judging
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("time_sorted_event_table_core: match");
        end else begin
            $display("time_sorted_event_table_core: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/tset_pkg.sv
hdl/tset_ctrl.sv
hdl/tset_dpath.sv
hdl/time_sorted_event_table_core.sv
test/time_sorted_event_table_core_tb.sv
